// ----- hw/rtl/lowest_common_ancestor_lifting_defines.svh -----
// Assertion macros for the lowest common ancestor lifting engine checker.
`ifndef LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH
`define LOWEST_COMMON_ANCESTOR_LIFTING_DEFINES_SVH

// Check a property at every clock edge outside reset.
`define LCAL_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property at every clock edge, reset included.
`define LCAL_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- hw/rtl/lcal_pkg.sv -----
// Shared widths, codes and sequencer states of the lowest common ancestor lifting engine.
`default_nettype none

package lcal_pkg;

	localparam int NODE_W          = 10;
	localparam int DEPTH_W         = 10;
	localparam int ACTION_W        = 2;
	localparam int CFG_W           = 11;
	localparam int APB_AW          = 3;
	localparam int APB_DW          = 32;
	localparam int MAX_NODES_DEF   = 1024;
	localparam int LIFT_LEVELS_DEF = 10;

	localparam logic [CFG_W-1:0] NODE_COUNT_RST = 11'd1024;

	// Register index, taken from the word address bits of paddr
	localparam logic [APB_AW-3:0] REG_NODE_COUNT = 1'b0;

	typedef enum logic [ACTION_W-1:0] {
		ACT_LOAD  = 2'd0,
		ACT_BUILD = 2'd1,
		ACT_QUERY = 2'd2
	} action_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_WRAP,
		ST_DISPATCH,
		ST_BLD_A,
		ST_BLD_B,
		ST_BLD_C,
		ST_DIFF,
		ST_UP,
		ST_UP_W,
		ST_EQ,
		ST_PAIR,
		ST_PAIR_W,
		ST_LAST,
		ST_LAST_W,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lcal_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
`default_nettype none

module lcal_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr_a,
	output logic [WIDTH-1:0] rdata_a,
	input  logic [AW-1:0]    raddr_b,
	output logic [WIDTH-1:0] rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one entry
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Register both read ports
	always_ff @(posedge clk) begin
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

`default_nettype wire

// ----- hw/rtl/lowest_common_ancestor_lifting.sv -----
// Binary-lifting lowest common ancestor engine: sequencer, lifting table and depth table.
//
// A load request writes one node's depth and parent. A build request fills lifting levels
// 1 and up through ST_BLD_A, ST_BLD_B and ST_BLD_C per node and level, for the nodes below
// count, the smaller of node_count and MAX_NODES. A query request first lifts the deeper
// node by the set bits of the depth difference; when the nodes then differ, it lifts both
// together from the top level down and then takes the parent of the result. Every table
// step is one registered read of the lifting table, which serves one lookup at a time
// during the build and a pair of lookups during the joint lift; the request side stays
// stalled until the item is done. When MAX_NODES is below 1024, each request first reduces
// its node numbers modulo MAX_NODES in ST_WRAP, one compare and subtract per cycle.
// Neither table is cleared after reset: a query or build must only read entries that a
// load or an earlier build has written. A finished answer waits in an output register,
// so a new request is taken while it is still stalled.
`default_nettype none

module lowest_common_ancestor_lifting import lcal_pkg::*; #(
	parameter int MAX_NODES   = MAX_NODES_DEF,
	parameter int LIFT_LEVELS = LIFT_LEVELS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// Configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [APB_AW-1:0]   paddr,
	input  logic [APB_DW-1:0]   pwdata,
	output logic [APB_DW-1:0]   prdata,
	output logic                pready,
	// Request channel
	input  logic                req_valid,
	output logic                req_stall,
	input  logic [ACTION_W-1:0] action,
	input  logic [NODE_W-1:0]   node,
	input  logic [NODE_W-1:0]   parent_node,
	input  logic [DEPTH_W-1:0]  node_depth,
	input  logic [NODE_W-1:0]   other_node,
	// Result channel
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output logic [NODE_W-1:0]   ancestor_node
);

	localparam int NODE_AW    = $clog2(MAX_NODES);
	localparam int LIFT_DEPTH = MAX_NODES * LIFT_LEVELS;
	localparam int LIFT_AW    = $clog2(LIFT_DEPTH);
	localparam int LVL_W      = (LIFT_LEVELS > 1) ? $clog2(LIFT_LEVELS) : 1;
	localparam int NODE_MAXV  = (1 << NODE_W) - 1;
	localparam int WRAP_STEPS = (MAX_NODES > NODE_MAXV) ? 0 :
		$clog2(NODE_MAXV / MAX_NODES + 1);
	localparam int WS_W       = (WRAP_STEPS > 1) ? $clog2(WRAP_STEPS) : 1;
	localparam int CNT_W      = ($clog2(MAX_NODES + 1) > CFG_W) ? $clog2(MAX_NODES + 1) :
		CFG_W;
	localparam logic [DEPTH_W-1:0] DIFF_MASK = (LIFT_LEVELS >= DEPTH_W) ?
		{DEPTH_W{1'b1}} : DEPTH_W'((1 << LIFT_LEVELS) - 1);
	localparam logic [LVL_W-1:0] TOP_LVL = LVL_W'(LIFT_LEVELS - 1);

	// Row-major position of (node, level) in the lifting table
	function automatic logic [LIFT_AW-1:0] lift_addr(input logic [NODE_AW-1:0] n,
		input logic [LVL_W-1:0] l);
		return LIFT_AW'(n) * LIFT_AW'(LIFT_LEVELS) + LIFT_AW'(l);
	endfunction

	state_t state_q, state_d;
	action_t act_q;

	logic [NODE_W-1:0]  a_q;
	logic [NODE_W-1:0]  b_q;
	logic [NODE_W-1:0]  par_q;
	logic [DEPTH_W-1:0] dep_q;
	logic [DEPTH_W-1:0] diff_q;
	logic [LVL_W-1:0]   lvl_q;
	logic [NODE_AW-1:0] idx_q;
	logic [WS_W-1:0]    wrap_cnt_q;
	logic [CFG_W-1:0]   node_count_q;
	logic               rsp_valid_q;
	logic [NODE_W-1:0]  ancestor_q;

	logic [NODE_W-1:0]  wrap_mod;
	logic [CNT_W-1:0]   count_eff;
	logic [NODE_AW-1:0] build_last;
	logic               build_none;
	logic [LVL_W-1:0]   lvl_dn;
	logic               swap;
	logic [DEPTH_W-1:0] diff_abs;
	logic               out_load;
	logic               cfg_write;

	logic               dep_we;
	logic [NODE_AW-1:0] dep_raddr_a;
	logic [NODE_AW-1:0] dep_raddr_b;
	logic [DEPTH_W-1:0] dep_rd_a;
	logic [DEPTH_W-1:0] dep_rd_b;
	logic               lift_we;
	logic [LIFT_AW-1:0] lift_waddr;
	logic [NODE_W-1:0]  lift_wdata;
	logic [LIFT_AW-1:0] lift_raddr_a;
	logic [LIFT_AW-1:0] lift_raddr_b;
	logic [NODE_W-1:0]  lift_rd_a;
	logic [NODE_W-1:0]  lift_rd_b;

	// Configuration register
	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite &&
		(paddr[APB_AW-1:2] == REG_NODE_COUNT);
	assign prdata    = (paddr[APB_AW-1:2] == REG_NODE_COUNT) ?
		APB_DW'(node_count_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RST;
		end else if (cfg_write) begin
			node_count_q <= pwdata[CFG_W-1:0];
		end
	end

	// Build sweep bounds
	assign count_eff  = (CNT_W'(node_count_q) > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) :
		CNT_W'(node_count_q);
	assign build_last = NODE_AW'(count_eff - CNT_W'(1));
	assign build_none = (count_eff == '0) || (LIFT_LEVELS == 1);

	// Shared arithmetic helpers
	assign wrap_mod = NODE_W'(MAX_NODES) << wrap_cnt_q;
	assign lvl_dn   = lvl_q - LVL_W'(1);
	assign swap     = dep_rd_a < dep_rd_b;
	assign diff_abs = swap ? (dep_rd_b - dep_rd_a) : (dep_rd_a - dep_rd_b);
	assign out_load = (state_q == ST_OUT) && (!rsp_valid_q || !rsp_stall);

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Sequence the table accesses
	always_comb begin
		state_d      = state_q;
		req_stall    = (state_q != ST_IDLE);
		dep_we       = 1'b0;
		dep_raddr_a  = NODE_AW'(a_q);
		dep_raddr_b  = NODE_AW'(b_q);
		lift_we      = 1'b0;
		lift_waddr   = lift_addr(idx_q, lvl_q);
		lift_wdata   = lift_rd_a;
		lift_raddr_a = lift_addr(NODE_AW'(a_q), lvl_q);
		lift_raddr_b = lift_addr(NODE_AW'(b_q), lvl_q);
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = (WRAP_STEPS > 0) ? ST_WRAP : ST_DISPATCH;
				end
			end
			ST_WRAP: begin
				if (wrap_cnt_q == '0) begin
					state_d = ST_DISPATCH;
				end
			end
			ST_DISPATCH: begin
				case (act_q)
					ACT_LOAD: begin
						dep_we     = 1'b1;
						lift_we    = 1'b1;
						lift_waddr = lift_addr(NODE_AW'(a_q), '0);
						lift_wdata = par_q;
						state_d    = ST_IDLE;
					end
					ACT_BUILD: begin
						state_d = build_none ? ST_IDLE : ST_BLD_A;
					end
					ACT_QUERY: begin
						state_d = ST_DIFF;
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_BLD_A: begin
				lift_raddr_a = lift_addr(idx_q, lvl_dn);
				state_d      = ST_BLD_B;
			end
			ST_BLD_B: begin
				lift_raddr_a = lift_addr(NODE_AW'(lift_rd_a), lvl_dn);
				state_d      = ST_BLD_C;
			end
			ST_BLD_C: begin
				lift_we = 1'b1;
				if ((idx_q == build_last) && (lvl_q == TOP_LVL)) begin
					state_d = ST_IDLE;
				end else begin
					state_d = ST_BLD_A;
				end
			end
			ST_DIFF: begin
				state_d = ST_UP;
			end
			ST_UP: begin
				if (diff_q == '0) begin
					state_d = ST_EQ;
				end else if (diff_q[0]) begin
					state_d = ST_UP_W;
				end
			end
			ST_UP_W: begin
				state_d = ST_UP;
			end
			ST_EQ: begin
				state_d = (a_q == b_q) ? ST_OUT : ST_PAIR;
			end
			ST_PAIR: begin
				state_d = ST_PAIR_W;
			end
			ST_PAIR_W: begin
				state_d = (lvl_q == '0) ? ST_LAST : ST_PAIR;
			end
			ST_LAST: begin
				state_d = ST_LAST_W;
			end
			ST_LAST_W: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Advance the working registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					act_q      <= action_t'(action);
					a_q        <= node;
					b_q        <= other_node;
					par_q      <= parent_node;
					dep_q      <= node_depth;
					wrap_cnt_q <= WS_W'(WRAP_STEPS - 1);
				end
			end
			ST_WRAP: begin
				if (a_q >= wrap_mod) begin
					a_q <= a_q - wrap_mod;
				end
				if (b_q >= wrap_mod) begin
					b_q <= b_q - wrap_mod;
				end
				if (par_q >= wrap_mod) begin
					par_q <= par_q - wrap_mod;
				end
				wrap_cnt_q <= wrap_cnt_q - WS_W'(1);
			end
			ST_DISPATCH: begin
				lvl_q <= LVL_W'(1);
				idx_q <= '0;
			end
			ST_BLD_C: begin
				if (idx_q == build_last) begin
					idx_q <= '0;
					lvl_q <= lvl_q + LVL_W'(1);
				end else begin
					idx_q <= idx_q + NODE_AW'(1);
				end
			end
			ST_DIFF: begin
				if (swap) begin
					a_q <= b_q;
					b_q <= a_q;
				end
				diff_q <= diff_abs & DIFF_MASK;
				lvl_q  <= '0;
			end
			ST_UP: begin
				if ((diff_q != '0) && !diff_q[0]) begin
					diff_q <= diff_q >> 1;
					lvl_q  <= lvl_q + LVL_W'(1);
				end
			end
			ST_UP_W: begin
				a_q    <= lift_rd_a;
				diff_q <= diff_q >> 1;
				lvl_q  <= lvl_q + LVL_W'(1);
			end
			ST_EQ: begin
				lvl_q <= TOP_LVL;
			end
			ST_PAIR_W: begin
				if (lift_rd_a != lift_rd_b) begin
					a_q <= lift_rd_a;
					b_q <= lift_rd_b;
				end
				if (lvl_q != '0) begin
					lvl_q <= lvl_q - LVL_W'(1);
				end
			end
			ST_LAST_W: begin
				a_q <= lift_rd_a;
			end
			default: begin
			end
		endcase
	end

	// Hold the answer until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (out_load) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			ancestor_q <= a_q;
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign ancestor_node = ancestor_q;

	// Depth of every node
	lcal_ram #(
		.WIDTH(DEPTH_W),
		.DEPTH(MAX_NODES)
	) u_depth_ram (
		.clk    (clk),
		.we     (dep_we),
		.waddr  (NODE_AW'(a_q)),
		.wdata  (dep_q),
		.raddr_a(dep_raddr_a),
		.rdata_a(dep_rd_a),
		.raddr_b(dep_raddr_b),
		.rdata_b(dep_rd_b)
	);

	// Ancestor 2^level steps up, per node and level
	lcal_ram #(
		.WIDTH(NODE_W),
		.DEPTH(LIFT_DEPTH)
	) u_lift_ram (
		.clk    (clk),
		.we     (lift_we),
		.waddr  (lift_waddr),
		.wdata  (lift_wdata),
		.raddr_a(lift_raddr_a),
		.rdata_a(lift_rd_a),
		.raddr_b(lift_raddr_b),
		.rdata_b(lift_rd_b)
	);

endmodule

`default_nettype wire

// ----- hw/rtl/lcal_checker.sv -----
// Port-level checker for the lowest common ancestor lifting engine, bound to the top level.
`default_nettype none

`include "lowest_common_ancestor_lifting_defines.svh"

module lcal_checker import lcal_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              req_valid,
	input logic              req_stall,
	input logic              rsp_valid,
	input logic              rsp_stall,
	input logic [NODE_W-1:0] ancestor_node
);

	// Reset leaves no answer pending and the request side open
	`LCAL_ASSERT_ALWAYS(a_reset_idle, !arst_n |-> (!rsp_valid && !req_stall), "busy in reset")

	// One request at a time: the block is busy right after taking one
	`LCAL_ASSERT(a_busy_after_req, (req_valid && !req_stall) |=> req_stall, "no busy after req")

	// A new answer appears only as a query finishes and frees the request side
	`LCAL_ASSERT(a_answer_ends_item, $rose(rsp_valid) |-> (!req_stall && $past(req_stall)), "stray answer")

	// A stalled answer stays put
	`LCAL_ASSERT(a_rsp_hold, (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(ancestor_node)), "answer changed")

endmodule

bind lowest_common_ancestor_lifting lcal_checker u_checker (.*);

`default_nettype wire
